FILE: rtl/stt_pkg.sv
// Shared types, constants and character-class helpers for the source text tokenizer.
`default_nettype none

package stt_pkg;

	localparam int CHAR_W   = 8;
	localparam int KIND_W   = 5;
	localparam int OFFSET_W = 32;
	localparam int LENGTH_W = 16;
	localparam int VALUE_W  = 63;
	localparam int WINDOW_W = 48;

	localparam logic [LENGTH_W-1:0] LEN_CAP   = 16'hFFFF;
	localparam logic [VALUE_W-1:0]  VALUE_MAX = {VALUE_W{1'b1}};

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_IDENT   = 3'd2,
		MODE_NUMBER  = 3'd3,
		MODE_LT      = 3'd4,
		MODE_GT      = 3'd5,
		MODE_EQ      = 3'd6
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		K_EOI     = 5'd0,
		K_LPAREN  = 5'd1,
		K_RPAREN  = 5'd2,
		K_LBRACK  = 5'd3,
		K_RBRACK  = 5'd4,
		K_LBRACE  = 5'd5,
		K_RBRACE  = 5'd6,
		K_COLON   = 5'd7,
		K_COMMA   = 5'd8,
		K_LE      = 5'd9,
		K_LT      = 5'd10,
		K_GE      = 5'd11,
		K_GT      = 5'd12,
		K_EQEQ    = 5'd13,
		K_ASSIGN  = 5'd14,
		K_IDENT   = 5'd15,
		K_INT     = 5'd16,
		K_META    = 5'd17,
		K_CONST   = 5'd18,
		K_FINAL   = 5'd19,
		K_VAR     = 5'd20,
		K_PUBLIC  = 5'd21,
		K_EXTERN  = 5'd22,
		K_FUN     = 5'd23,
		K_UNKNOWN = 5'd24
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [OFFSET_W-1:0]  offset;
		logic [LENGTH_W-1:0]  length;
		logic [VALUE_W-1:0]   value;
		logic                 ovf;
		logic                 last;
	} tok_t;

	typedef struct packed {
		logic [WINDOW_W-1:0] pattern;
		logic [LENGTH_W-1:0] len;
		kind_t               kind;
	} kw_entry_t;

	localparam int KW_COUNT = 7;

	localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
		'{48'h0000_6D65_7461, 16'd4, K_META},
		'{48'h0063_6F6E_7374, 16'd5, K_CONST},
		'{48'h0066_696E_616C, 16'd5, K_FINAL},
		'{48'h0000_0076_6172, 16'd3, K_VAR},
		'{48'h7075_626C_6963, 16'd6, K_PUBLIC},
		'{48'h6578_7465_726E, 16'd6, K_EXTERN},
		'{48'h0000_0066_756E, 16'd3, K_FUN}
	};

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_ident_start(input logic [CHAR_W-1:0] c);
		return (c == "_") || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
	endfunction

	// K_EOI stands for "not a punctuation byte"
	function automatic kind_t punct_kind(input logic [CHAR_W-1:0] c);
		kind_t k;
		case (c)
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			":": k = K_COLON;
			",": k = K_COMMA;
			default: k = K_EOI;
		endcase
		return k;
	endfunction

	function automatic kind_t kw_lookup(input logic [LENGTH_W-1:0] len,
					    input logic [WINDOW_W-1:0] window);
		kind_t k;
		k = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if ((len == KW_TABLE[i].len) && (window == KW_TABLE[i].pattern)) begin
				k = KW_TABLE[i].kind;
			end
		end
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/stt_in_if.sv
// Byte input channel of the tokenizer.
`default_nettype none

interface stt_in_if;
	logic                        valid;
	logic                        ready;
	logic [stt_pkg::CHAR_W-1:0]  char_code;
	logic                        end_of_input;

	modport source (output valid, output char_code, output end_of_input, input ready);
	modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

FILE: rtl/stt_out_if.sv
// Token output channel of the tokenizer.
`default_nettype none

interface stt_out_if;
	logic                          valid;
	logic                          ready;
	logic [stt_pkg::KIND_W-1:0]    token_kind;
	logic [stt_pkg::OFFSET_W-1:0]  token_offset;
	logic [stt_pkg::LENGTH_W-1:0]  token_length;
	logic [stt_pkg::VALUE_W-1:0]   int_value;
	logic                          value_overflow;
	logic                          last_of_run;

	modport source (output valid, output token_kind, output token_offset,
			output token_length, output int_value, output value_overflow,
			output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_offset,
		      input token_length, input int_value, input value_overflow,
		      input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/source_text_tokenizer_unit.sv
// Source text tokenizer: one byte per transfer in, tokens out.
//
// in_ch carries one source byte (or an end-of-input mark) per transfer.
// out_ch carries tokens with kind, start offset, length, integer value and
// overflow flag; last_of_run marks the final token caused by one input.
// A byte yields zero, one or two tokens; an end mark yields one or two.
// The first token of a transfer is on out_ch the cycle after its input transfer.
// Throughput: one byte per cycle while each byte yields at most one token and
// the receiver is ready; a byte that yields two tokens holds input until its
// first token is taken, set by the two-entry token queue at the output.
// Input is taken whenever the queue will be empty after this cycle's output
// transfer, so a waiting token does not block the next byte.
// When the receiver stalls, queued tokens hold and input backs up once the
// queue holds two tokens or one that is not being taken.
// Reset clears the scanner to idle at offset zero and empties the queue.
`default_nettype none

module source_text_tokenizer_unit (
	input  wire          clk,
	input  wire          arst_n,
	stt_in_if.sink       in_ch,
	stt_out_if.source    out_ch
);

	// scanner state
	stt_pkg::mode_t                      mode_q;
	logic [stt_pkg::OFFSET_W-1:0]        off_q;
	logic [stt_pkg::OFFSET_W-1:0]        start_q;
	logic [stt_pkg::LENGTH_W-1:0]        len_q;
	logic [stt_pkg::WINDOW_W-1:0]        win_q;
	logic [stt_pkg::VALUE_W-1:0]         acc_q;
	logic                                ovf_q;

	stt_pkg::mode_t                      mode_d;
	logic [stt_pkg::OFFSET_W-1:0]        off_d;
	logic [stt_pkg::OFFSET_W-1:0]        start_d;
	logic [stt_pkg::LENGTH_W-1:0]        len_d;
	logic [stt_pkg::WINDOW_W-1:0]        win_d;
	logic [stt_pkg::VALUE_W-1:0]         acc_d;
	logic                                ovf_d;

	// token queue
	stt_pkg::tok_t                       slot0_q;
	stt_pkg::tok_t                       slot1_q;
	logic [1:0]                          cnt_q;

	logic                                in_fire;
	logic                                out_fire;
	logic [stt_pkg::CHAR_W-1:0]          c;

	stt_pkg::tok_t                       flush_tok;
	logic                                flush_v;
	stt_pkg::tok_t                       tail_tok;
	logic                                tail_v;
	logic                                head_v;
	stt_pkg::tok_t                       tok0;
	stt_pkg::tok_t                       tok1;
	logic [1:0]                          n_tok;

	logic [stt_pkg::VALUE_W+3:0]         prod;
	logic [stt_pkg::VALUE_W-1:0]         digit_val;

	assign c        = in_ch.char_code;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign in_ch.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ch.ready);
	assign in_fire  = in_ch.valid && in_ch.ready;

	assign digit_val = {{(stt_pkg::VALUE_W-4){1'b0}}, 4'(c - "0")};
	// acc * 10 + digit, wide enough to never wrap
	assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		    + {4'b0000, digit_val};

	// pending token that a terminating byte or end mark flushes
	always_comb begin
		flush_tok        = '0;
		flush_tok.offset = start_q;
		flush_v          = 1'b1;
		case (mode_q)
			stt_pkg::MODE_IDENT: begin
				flush_tok.kind   = stt_pkg::kw_lookup(len_q, win_q);
				flush_tok.length = len_q;
			end
			stt_pkg::MODE_NUMBER: begin
				flush_tok.kind   = stt_pkg::K_INT;
				flush_tok.length = len_q;
				flush_tok.value  = acc_q;
				flush_tok.ovf    = ovf_q;
			end
			stt_pkg::MODE_LT: begin
				flush_tok.kind   = stt_pkg::K_LT;
				flush_tok.length = 16'd1;
			end
			stt_pkg::MODE_GT: begin
				flush_tok.kind   = stt_pkg::K_GT;
				flush_tok.length = 16'd1;
			end
			stt_pkg::MODE_EQ: begin
				flush_tok.kind   = stt_pkg::K_ASSIGN;
				flush_tok.length = 16'd1;
			end
			default: flush_v = 1'b0;
		endcase
	end

	// next state and the tokens of this transfer
	always_comb begin
		logic do_idle;
		logic use_flush;
		stt_pkg::kind_t pk;

		mode_d    = mode_q;
		off_d     = off_q;
		start_d   = start_q;
		len_d     = len_q;
		win_d     = win_q;
		acc_d     = acc_q;
		ovf_d     = ovf_q;
		do_idle   = 1'b0;
		use_flush = 1'b0;
		tail_tok  = '0;
		tail_tok.offset = off_q;
		tail_v    = 1'b0;
		pk        = stt_pkg::punct_kind(c);

		if (in_ch.end_of_input) begin
			use_flush     = 1'b1;
			mode_d        = stt_pkg::MODE_IDLE;
			tail_tok.kind = stt_pkg::K_EOI;
			tail_v        = 1'b1;
		end else begin
			off_d = off_q + 32'd1;
			case (mode_q)
				stt_pkg::MODE_COMMENT: begin
					if (c == 8'h0A) begin
						mode_d = stt_pkg::MODE_IDLE;
					end
				end
				stt_pkg::MODE_IDENT: begin
					if (stt_pkg::is_ident_start(c) || stt_pkg::is_digit(c)) begin
						if (len_q < stt_pkg::LEN_CAP) begin
							len_d = len_q + 16'd1;
						end
						win_d = {win_q[stt_pkg::WINDOW_W-9:0], c};
					end else begin
						use_flush = 1'b1;
						do_idle   = 1'b1;
					end
				end
				stt_pkg::MODE_NUMBER: begin
					if (stt_pkg::is_digit(c)) begin
						if (len_q < stt_pkg::LEN_CAP) begin
							len_d = len_q + 16'd1;
						end
						if (prod > {4'b0000, stt_pkg::VALUE_MAX}) begin
							acc_d = stt_pkg::VALUE_MAX;
							ovf_d = 1'b1;
						end else begin
							acc_d = prod[stt_pkg::VALUE_W-1:0];
						end
					end else begin
						use_flush = 1'b1;
						do_idle   = 1'b1;
					end
				end
				stt_pkg::MODE_LT, stt_pkg::MODE_GT, stt_pkg::MODE_EQ: begin
					if (c == "=") begin
						tail_v          = 1'b1;
						tail_tok.offset = start_q;
						tail_tok.length = 16'd2;
						tail_tok.kind   = (mode_q == stt_pkg::MODE_LT) ? stt_pkg::K_LE :
								  (mode_q == stt_pkg::MODE_GT) ? stt_pkg::K_GE :
								  stt_pkg::K_EQEQ;
						mode_d = stt_pkg::MODE_IDLE;
					end else begin
						use_flush = 1'b1;
						do_idle   = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase

			// scan the byte itself from idle
			if (do_idle) begin
				mode_d          = stt_pkg::MODE_IDLE;
				tail_tok.length = 16'd1;
				if (pk != stt_pkg::K_EOI) begin
					tail_tok.kind = pk;
					tail_v        = 1'b1;
				end else if (!stt_pkg::is_space(c)) begin
					start_d = off_q;
					if (c == "#") begin
						mode_d = stt_pkg::MODE_COMMENT;
					end else if (c == "<") begin
						mode_d = stt_pkg::MODE_LT;
					end else if (c == ">") begin
						mode_d = stt_pkg::MODE_GT;
					end else if (c == "=") begin
						mode_d = stt_pkg::MODE_EQ;
					end else if (stt_pkg::is_ident_start(c)) begin
						mode_d = stt_pkg::MODE_IDENT;
						len_d  = 16'd1;
						win_d  = {{(stt_pkg::WINDOW_W-8){1'b0}}, c};
					end else if (stt_pkg::is_digit(c)) begin
						mode_d = stt_pkg::MODE_NUMBER;
						len_d  = 16'd1;
						acc_d  = digit_val;
						ovf_d  = 1'b0;
					end else begin
						tail_tok.kind = stt_pkg::K_UNKNOWN;
						tail_v        = 1'b1;
					end
				end
			end
		end

		head_v = use_flush && flush_v;
	end

	// pack the tokens of this transfer, the final one marked last
	always_comb begin
		tok0 = head_v ? flush_tok : tail_tok;
		tok1 = tail_tok;
		n_tok = {1'b0, head_v} + {1'b0, tail_v};
		tok0.last = (n_tok == 2'd1);
		tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stt_pkg::MODE_IDLE;
			off_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			win_q   <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (in_fire) begin
			mode_q  <= mode_d;
			off_q   <= off_d;
			start_q <= start_d;
			len_q   <= len_d;
			win_q   <= win_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_fire) begin
			cnt_q <= n_tok;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// a taken transfer overwrites both slots, as the old queue is then drained
	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot0_q <= tok0;
			slot1_q <= tok1;
		end else if (out_fire) begin
			slot0_q <= slot1_q;
		end
	end

	assign out_ch.valid          = (cnt_q != 2'd0);
	assign out_ch.token_kind     = slot0_q.kind;
	assign out_ch.token_offset   = slot0_q.offset;
	assign out_ch.token_length   = slot0_q.length;
	assign out_ch.int_value      = slot0_q.value;
	assign out_ch.value_overflow = slot0_q.ovf;
	assign out_ch.last_of_run    = slot0_q.last;

endmodule

`default_nettype wire
